// File: src/lrst_pkg.sv
// Shared types, constants and opcodes for the lazy range add/set query tree.
package lrst_pkg;

	localparam int LEAVES_DEF = 1024;
	localparam int ANS_W      = 48;
	localparam int VAL_W      = 32;
	localparam int OP_W       = 3;
	localparam int LOW_W      = 10;
	localparam int HIGH_W     = 11;
	localparam int ULEN_W     = 11;
	localparam logic [ULEN_W-1:0] ULEN_RESET = 11'd1024;

	localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;
	localparam logic [VAL_W-1:0] INT_MAX = 32'h7FFF_FFFF;

	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_ASSIGN = 3'd1;
	localparam logic [OP_W-1:0] OP_SUM    = 3'd2;
	localparam logic [OP_W-1:0] OP_MIN    = 3'd3;
	localparam logic [OP_W-1:0] OP_MAX    = 3'd4;

	typedef struct packed {
		logic [ANS_W-1:0] sum;
		logic [VAL_W-1:0] mn;
		logic [VAL_W-1:0] mx;
	} agg_t;

	typedef struct packed {
		logic [VAL_W-1:0] padd;
		logic [VAL_W-1:0] pasg;
		logic             aflag;
	} mark_t;

	localparam int AGG_W  = $bits(agg_t);
	localparam int MARK_W = $bits(mark_t);

endpackage

// File: src/lrst_ram.sv
// Simple dual-port node memory with registered read data.
module lrst_ram #(
	parameter int W     = lrst_pkg::AGG_W,
	parameter int DEPTH = 4 * lrst_pkg::LEAVES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/lrst_mul.sv
// Shared length-by-value multiplier, registered output, wraps to 48 bits.
module lrst_mul #(
	parameter int PW = 11
) (
	input  logic                                clk,
	input  logic [PW-1:0]                       len,
	input  logic signed [lrst_pkg::VAL_W-1:0]   d,
	output logic signed [lrst_pkg::ANS_W-1:0]   prod_q
);
	logic signed [PW+lrst_pkg::VAL_W:0] full;

	assign full = $signed({1'b0, len}) * d;

	always_ff @(posedge clk) begin
		prod_q <= lrst_pkg::ANS_W'(full);
	end
endmodule

// File: src/lazy_range_add_set_query_tree.sv
// Top level: lazy segment tree sequencer with range add, assign and queries.
//
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    operation, range_low, range_high, value
// out      out  out_valid / out_ready  answer, range_error
// cfg      in   cfg_we                 cfg_wdata (used_length)
//
// One item at a time, paced by the single node memory read port and the shared
// multiplier: each node the range covers is read and then marked or folded into
// the answer; each node it splits takes two child pushes and a stack push, plus a
// parent pull for add and assign. Bad ranges and unknown operations skip the walk.
// After reset a clearing pass writes 4*LEAVES node slots, one per cycle,
// before in_ready rises. A result waits in the output register; a new item
// may be accepted meanwhile.
module lazy_range_add_set_query_tree #(
	parameter int LEAVES = lrst_pkg::LEAVES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lrst_pkg::ULEN_W-1:0]        cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lrst_pkg::OP_W-1:0]          operation,
	input  logic [lrst_pkg::LOW_W-1:0]         range_low,
	input  logic [lrst_pkg::HIGH_W-1:0]        range_high,
	input  logic signed [lrst_pkg::VAL_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lrst_pkg::ANS_W-1:0]  answer,
	output logic                               range_error
);
	localparam int NODES = 4 * LEAVES;
	localparam int NW    = $clog2(NODES);
	localparam int PW    = $clog2(LEAVES + 1);
	localparam int CW    = (PW > lrst_pkg::HIGH_W) ? PW : lrst_pkg::HIGH_W;
	localparam int DEPTH = $clog2(LEAVES) + 1;
	localparam int SIW   = $clog2(DEPTH);
	localparam int SPW   = $clog2(DEPTH + 1);

	localparam logic [4:0] ST_CLR  = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_RD   = 5'd2;
	localparam logic [4:0] ST_NODE = 5'd3;
	localparam logic [4:0] ST_MARK = 5'd4;
	localparam logic [4:0] ST_PRD  = 5'd5;
	localparam logic [4:0] ST_PLD  = 5'd6;
	localparam logic [4:0] ST_PAS  = 5'd7;
	localparam logic [4:0] ST_PAD  = 5'd8;
	localparam logic [4:0] ST_PWR  = 5'd9;
	localparam logic [4:0] ST_PPW  = 5'd10;
	localparam logic [4:0] ST_RET  = 5'd11;
	localparam logic [4:0] ST_LRA  = 5'd12;
	localparam logic [4:0] ST_LRB  = 5'd13;
	localparam logic [4:0] ST_LWR  = 5'd14;
	localparam logic [4:0] ST_POP  = 5'd15;
	localparam logic [4:0] ST_DONE = 5'd16;

	logic [4:0] state_q;
	logic [NW-1:0] clr_q;
	logic [lrst_pkg::ULEN_W-1:0] ulen_q;

	logic [lrst_pkg::OP_W-1:0] op_q;
	logic [CW-1:0] l_q, r_q;
	logic signed [lrst_pkg::VAL_W-1:0] v_q;
	logic [lrst_pkg::ANS_W-1:0] acc_q;
	logic err_q;
	logic k_q;

	logic [NW-1:0] top_n_q;
	logic [PW-1:0] top_lo_q, top_hi_q;
	logic [1:0]    top_ph_q;
	logic [NW-1:0] stk_n  [DEPTH];
	logic [PW-1:0] stk_lo [DEPTH];
	logic [PW-1:0] stk_hi [DEPTH];
	logic [1:0]    stk_ph [DEPTH];
	logic [SPW-1:0] sp_q, spm1;

	lrst_pkg::agg_t  r_agg, cur_agg_q, chd_agg_q, agg_wd;
	lrst_pkg::mark_t r_mk, cur_mk_q, chd_mk_q, mk_wd;
	logic agg_we, mk_we;
	logic [NW-1:0] waddr, raddr;

	logic [PW-1:0] mul_len;
	logic signed [lrst_pkg::VAL_W-1:0] mul_d;
	logic signed [lrst_pkg::ANS_W-1:0] prod_q;

	logic [PW:0] mid_w;
	logic [PW-1:0] mid, len_c, len_n;
	logic covered, is_apply, is_assign, in_acc, bad;
	logic [CW-1:0] len_eff;
	logic [NW-1:0] child_l, child_r, child_k;

	assign mid_w    = ({1'b0, top_lo_q} + {1'b0, top_hi_q}) >> 1;
	assign mid      = mid_w[PW-1:0];
	assign len_n    = top_hi_q - top_lo_q;
	assign len_c    = k_q ? (top_hi_q - mid) : (mid - top_lo_q);
	assign child_l  = {top_n_q[NW-2:0], 1'b0};
	assign child_r  = {top_n_q[NW-2:0], 1'b1};
	assign child_k  = {top_n_q[NW-2:0], k_q};
	assign covered  = (l_q <= CW'(top_lo_q)) && (CW'(top_hi_q) <= r_q);
	assign is_apply = (op_q == lrst_pkg::OP_ADD) || (op_q == lrst_pkg::OP_ASSIGN);
	assign is_assign = (op_q == lrst_pkg::OP_ASSIGN);
	assign spm1     = sp_q - SPW'(1);
	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign len_eff = (CW'(ulen_q) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(ulen_q);
	assign bad = (CW'(range_low) >= CW'(range_high)) || (CW'(range_high) > len_eff);

	lrst_ram #(.W(lrst_pkg::AGG_W), .DEPTH(NODES), .AW(NW)) u_agg (
		.clk(clk), .we(agg_we), .waddr(waddr), .wdata(agg_wd),
		.raddr(raddr), .rdata(r_agg)
	);

	lrst_ram #(.W(lrst_pkg::MARK_W), .DEPTH(NODES), .AW(NW)) u_mark (
		.clk(clk), .we(mk_we), .waddr(waddr), .wdata(mk_wd),
		.raddr(raddr), .rdata(r_mk)
	);

	lrst_mul #(.PW(PW)) u_mul (
		.clk(clk), .len(mul_len), .d(mul_d), .prod_q(prod_q)
	);

	always_comb begin
		mul_len = len_n;
		mul_d   = v_q;
		raddr   = top_n_q;
		agg_we  = 1'b0;
		mk_we   = 1'b0;
		waddr   = top_n_q;
		agg_wd  = chd_agg_q;
		mk_wd   = chd_mk_q;
		unique case (state_q)
			ST_CLR: begin
				agg_we = 1'b1;
				mk_we  = 1'b1;
				waddr  = clr_q;
				agg_wd = '0;
				mk_wd  = '0;
			end
			ST_MARK: begin
				agg_we = 1'b1;
				mk_we  = 1'b1;
				if (is_assign) begin
					agg_wd = '{sum: prod_q, mn: v_q, mx: v_q};
					mk_wd  = '{padd: '0, pasg: v_q, aflag: 1'b1};
				end else begin
					agg_wd = '{sum: cur_agg_q.sum + prod_q, mn: cur_agg_q.mn + v_q,
						mx: cur_agg_q.mx + v_q};
					mk_wd  = '{padd: cur_mk_q.padd + v_q, pasg: cur_mk_q.pasg,
						aflag: cur_mk_q.aflag};
				end
			end
			ST_PRD: raddr = child_k;
			ST_PLD: begin
				mul_len = len_c;
				mul_d   = cur_mk_q.pasg;
			end
			ST_PAS: begin
				mul_len = len_c;
				mul_d   = cur_mk_q.padd;
			end
			ST_PWR: begin
				agg_we = 1'b1;
				mk_we  = 1'b1;
				waddr  = child_k;
			end
			ST_PPW: begin
				mk_we = 1'b1;
				mk_wd = '{padd: '0, pasg: cur_mk_q.pasg, aflag: 1'b0};
			end
			ST_LRA: raddr = child_l;
			ST_LRB: raddr = child_r;
			ST_LWR: begin
				agg_we = 1'b1;
				agg_wd.sum = chd_agg_q.sum + r_agg.sum;
				agg_wd.mn  = ($signed(r_agg.mn) < $signed(chd_agg_q.mn)) ?
					r_agg.mn : chd_agg_q.mn;
				agg_wd.mx  = ($signed(chd_agg_q.mx) < $signed(r_agg.mx)) ?
					r_agg.mx : chd_agg_q.mx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			ulen_q    <= lrst_pkg::ULEN_RESET;
			sp_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				ulen_q <= cfg_wdata;
			end
			if ((state_q == ST_DONE) && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						op_q     <= operation;
						l_q      <= CW'(range_low);
						r_q      <= CW'(range_high);
						v_q      <= value;
						err_q    <= bad;
						top_n_q  <= NW'(1);
						top_lo_q <= '0;
						top_hi_q <= PW'(LEAVES);
						top_ph_q <= 2'd0;
						sp_q     <= '0;
						if (bad || (operation > lrst_pkg::OP_MAX)) begin
							acc_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							case (operation)
								lrst_pkg::OP_MIN:
									acc_q <= lrst_pkg::ANS_W'($signed(lrst_pkg::INT_MAX));
								lrst_pkg::OP_MAX:
									acc_q <= lrst_pkg::ANS_W'($signed(lrst_pkg::INT_MIN));
								default: acc_q <= '0;
							endcase
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: state_q <= ST_NODE;
				ST_NODE: begin
					cur_agg_q <= r_agg;
					cur_mk_q  <= r_mk;
					k_q       <= 1'b0;
					if (covered) begin
						if (is_apply) begin
							state_q <= ST_MARK;
						end else begin
							case (op_q)
								lrst_pkg::OP_SUM: acc_q <= acc_q + r_agg.sum;
								lrst_pkg::OP_MIN: begin
									if ($signed(r_agg.mn) < $signed(acc_q[lrst_pkg::VAL_W-1:0]))
										acc_q <= lrst_pkg::ANS_W'($signed(r_agg.mn));
								end
								default: begin
									if ($signed(acc_q[lrst_pkg::VAL_W-1:0]) < $signed(r_agg.mx))
										acc_q <= lrst_pkg::ANS_W'($signed(r_agg.mx));
								end
							endcase
							state_q <= ST_POP;
						end
					end else begin
						state_q <= ST_PRD;
					end
				end
				ST_MARK: state_q <= ST_POP;
				ST_PRD: state_q <= ST_PLD;
				ST_PLD: begin
					chd_agg_q <= r_agg;
					chd_mk_q  <= r_mk;
					state_q   <= ST_PAS;
				end
				ST_PAS: begin
					if (cur_mk_q.aflag) begin
						chd_agg_q <= '{sum: prod_q, mn: cur_mk_q.pasg, mx: cur_mk_q.pasg};
						chd_mk_q  <= '{padd: '0, pasg: cur_mk_q.pasg, aflag: 1'b1};
					end
					state_q <= ST_PAD;
				end
				ST_PAD: begin
					if (cur_mk_q.padd != '0) begin
						chd_agg_q.sum <= chd_agg_q.sum + prod_q;
						chd_agg_q.mn  <= chd_agg_q.mn + cur_mk_q.padd;
						chd_agg_q.mx  <= chd_agg_q.mx + cur_mk_q.padd;
						chd_mk_q.padd <= chd_mk_q.padd + cur_mk_q.padd;
					end
					state_q <= ST_PWR;
				end
				ST_PWR: begin
					k_q     <= 1'b1;
					state_q <= k_q ? ST_PPW : ST_PRD;
				end
				ST_PPW: begin
					stk_n[sp_q[SIW-1:0]]  <= top_n_q;
					stk_lo[sp_q[SIW-1:0]] <= top_lo_q;
					stk_hi[sp_q[SIW-1:0]] <= top_hi_q;
					sp_q     <= sp_q + SPW'(1);
					top_ph_q <= 2'd0;
					if (l_q < CW'(mid)) begin
						stk_ph[sp_q[SIW-1:0]] <= 2'd1;
						top_n_q  <= child_l;
						top_hi_q <= mid;
					end else begin
						stk_ph[sp_q[SIW-1:0]] <= 2'd2;
						top_n_q  <= child_r;
						top_lo_q <= mid;
					end
					state_q <= ST_RD;
				end
				ST_RET: begin
					if ((top_ph_q == 2'd1) && (r_q > CW'(mid))) begin
						stk_n[sp_q[SIW-1:0]]  <= top_n_q;
						stk_lo[sp_q[SIW-1:0]] <= top_lo_q;
						stk_hi[sp_q[SIW-1:0]] <= top_hi_q;
						stk_ph[sp_q[SIW-1:0]] <= 2'd2;
						sp_q     <= sp_q + SPW'(1);
						top_n_q  <= child_r;
						top_lo_q <= mid;
						top_ph_q <= 2'd0;
						state_q  <= ST_RD;
					end else begin
						state_q <= is_apply ? ST_LRA : ST_POP;
					end
				end
				ST_LRA: state_q <= ST_LRB;
				ST_LRB: begin
					chd_agg_q <= r_agg;
					state_q   <= ST_LWR;
				end
				ST_LWR: state_q <= ST_POP;
				ST_POP: begin
					if (sp_q == '0) begin
						if (is_apply) begin
							acc_q <= '0;
						end
						state_q <= ST_DONE;
					end else begin
						top_n_q  <= stk_n[spm1[SIW-1:0]];
						top_lo_q <= stk_lo[spm1[SIW-1:0]];
						top_hi_q <= stk_hi[spm1[SIW-1:0]];
						top_ph_q <= stk_ph[spm1[SIW-1:0]];
						sp_q     <= spm1;
						state_q  <= ST_RET;
					end
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid || out_ready)) begin
			answer      <= acc_q;
			range_error <= err_q;
		end
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SPW'(DEPTH) >= sp_q) else $error("node stack overflow");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (answer == '0)) else $error("error item nonzero");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready) else $error("ready while item in work");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_valid || out_ready)) |=> out_valid)
		else $error("result not posted");
endmodule

// File: dv/tb_lazy_range_add_set_query_tree.sv
// Testbench: random and directed range add, assign and query items against a tree predictor.
`timescale 1ns / 100ps

module tb_lazy_range_add_set_query_tree;

	localparam int LEAVES = lrst_pkg::LEAVES_DEF;
	localparam int NODES  = 4 * LEAVES;
	localparam int AW     = lrst_pkg::ANS_W;
	localparam int VW     = lrst_pkg::VAL_W;

	typedef struct packed {
		logic [lrst_pkg::OP_W-1:0]   op;
		logic [lrst_pkg::LOW_W-1:0]  lo;
		logic [lrst_pkg::HIGH_W-1:0] hi;
		logic [VW-1:0]               val;
		logic                        is_cfg;
	} req_t;

	typedef struct packed {
		logic [AW-1:0] ans;
		logic          err;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lrst_pkg::ULEN_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [lrst_pkg::OP_W-1:0] operation = '0;
	logic [lrst_pkg::LOW_W-1:0] range_low = '0;
	logic [lrst_pkg::HIGH_W-1:0] range_high = '0;
	logic signed [VW-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [AW-1:0] answer;
	logic range_error;

	lazy_range_add_set_query_tree u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor keeps its own lazy tree, pushing assign before add.
	logic [AW-1:0] t_sum  [NODES];
	logic [VW-1:0] t_min  [NODES];
	logic [VW-1:0] t_max  [NODES];
	logic [VW-1:0] t_padd [NODES];
	logic [VW-1:0] t_pasg [NODES];
	bit            t_af   [NODES];
	logic [lrst_pkg::ULEN_W-1:0] used_len = lrst_pkg::ULEN_RESET;
	req_t pending_q[$];
	res_t answers_q[$];
	int mismatches = 0, n_items = 0, n_results = 0, n_cfg = 0;
	bit calm = 0;
	int drain_wait = 0;

	function automatic logic [AW-1:0] ext32(logic [VW-1:0] v);
		return {{(AW - VW){v[VW-1]}}, v};
	endfunction

	function automatic void mark_add(int n, int len, logic [VW-1:0] d);
		t_min[n]  = t_min[n] + d;
		t_max[n]  = t_max[n] + d;
		t_sum[n]  = t_sum[n] + AW'(len) * ext32(d);
		t_padd[n] = t_padd[n] + d;
	endfunction

	function automatic void mark_assign(int n, int len, logic [VW-1:0] v);
		t_min[n]  = v;
		t_max[n]  = v;
		t_sum[n]  = AW'(len) * ext32(v);
		t_pasg[n] = v;
		t_af[n]   = 1'b1;
		t_padd[n] = '0;
	endfunction

	function automatic void t_push(int n, int lo, int hi);
		int mid;
		mid = (lo + hi) >> 1;
		if (t_af[n]) begin
			mark_assign(2 * n, mid - lo, t_pasg[n]);
			mark_assign(2 * n + 1, hi - mid, t_pasg[n]);
			t_af[n] = 1'b0;
		end
		if (t_padd[n] != '0) begin
			mark_add(2 * n, mid - lo, t_padd[n]);
			mark_add(2 * n + 1, hi - mid, t_padd[n]);
			t_padd[n] = '0;
		end
	endfunction

	function automatic void t_pull(int n);
		t_sum[n] = t_sum[2 * n] + t_sum[2 * n + 1];
		t_min[n] = ($signed(t_min[2 * n + 1]) < $signed(t_min[2 * n])) ?
			t_min[2 * n + 1] : t_min[2 * n];
		t_max[n] = ($signed(t_max[2 * n]) < $signed(t_max[2 * n + 1])) ?
			t_max[2 * n + 1] : t_max[2 * n];
	endfunction

	function automatic void t_apply(int n, int lo, int hi, int l, int r, bit asg,
			logic [VW-1:0] v);
		int mid;
		if (l <= lo && hi <= r) begin
			if (asg) mark_assign(n, hi - lo, v);
			else mark_add(n, hi - lo, v);
			return;
		end
		t_push(n, lo, hi);
		mid = (lo + hi) >> 1;
		if (l < mid) t_apply(2 * n, lo, mid, l, r, asg, v);
		if (r > mid) t_apply(2 * n + 1, mid, hi, l, r, asg, v);
		t_pull(n);
	endfunction

	function automatic bit better(logic [lrst_pkg::OP_W-1:0] kind, logic [AW-1:0] a,
			logic [AW-1:0] b);
		if (kind == lrst_pkg::OP_MIN)
			return $signed(a[VW-1:0]) < $signed(b[VW-1:0]);
		return $signed(b[VW-1:0]) < $signed(a[VW-1:0]);
	endfunction

	function automatic logic [AW-1:0] t_ask(int n, int lo, int hi, int l, int r,
			logic [lrst_pkg::OP_W-1:0] kind);
		int mid;
		logic [AW-1:0] acc, part;
		if (l <= lo && hi <= r) begin
			if (kind == lrst_pkg::OP_SUM) return t_sum[n];
			return ext32((kind == lrst_pkg::OP_MIN) ? t_min[n] : t_max[n]);
		end
		t_push(n, lo, hi);
		mid = (lo + hi) >> 1;
		if (kind == lrst_pkg::OP_SUM) begin
			acc = '0;
			if (l < mid) acc = acc + t_ask(2 * n, lo, mid, l, r, kind);
			if (r > mid) acc = acc + t_ask(2 * n + 1, mid, hi, l, r, kind);
			return acc;
		end
		acc = ext32((kind == lrst_pkg::OP_MIN) ? lrst_pkg::INT_MAX : lrst_pkg::INT_MIN);
		if (l < mid) begin
			part = t_ask(2 * n, lo, mid, l, r, kind);
			if (better(kind, part, acc)) acc = part;
		end
		if (r > mid) begin
			part = t_ask(2 * n + 1, mid, hi, l, r, kind);
			if (better(kind, part, acc)) acc = part;
		end
		return acc;
	endfunction

	function automatic res_t predict(req_t r);
		res_t o;
		int eff;
		eff = (int'(used_len) > LEAVES) ? LEAVES : int'(used_len);
		o = '0;
		if (int'(r.lo) >= int'(r.hi) || int'(r.hi) > eff) begin
			o.err = 1'b1;
			return o;
		end
		if (r.op == lrst_pkg::OP_ADD || r.op == lrst_pkg::OP_ASSIGN)
			t_apply(1, 0, LEAVES, int'(r.lo), int'(r.hi), r.op == lrst_pkg::OP_ASSIGN, r.val);
		else if (r.op <= lrst_pkg::OP_MAX)
			o.ans = t_ask(1, 0, LEAVES, int'(r.lo), int'(r.hi), r.op);
		return o;
	endfunction

	function automatic logic [VW-1:0] pick_val();
		case ($urandom_range(0, 5))
			0: return lrst_pkg::INT_MAX;
			1: return lrst_pkg::INT_MIN;
			2: return $urandom;
			default: return $urandom_range(0, 2000) - 1000;
		endcase
	endfunction

	task automatic push_item(int op, int lo, int hi, logic [VW-1:0] v);
		req_t r;
		r = '0;
		r.op = lrst_pkg::OP_W'(op);
		r.lo = lrst_pkg::LOW_W'(lo);
		r.hi = lrst_pkg::HIGH_W'(hi);
		r.val = v;
		pending_q.push_back(r);
	endtask

	task automatic push_len(int len);
		req_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.hi = lrst_pkg::HIGH_W'(len);
		pending_q.push_back(r);
	endtask

	// driver
	always @(posedge clk) begin
		logic wr_cfg;
		wr_cfg = 1'b0;
		if (in_valid && in_ready) begin
			answers_q.push_back(predict(pending_q.pop_front()));
			n_items++;
		end
		if (arst_n && pending_q.size() > 0 && !(in_valid && !in_ready)) begin
			if (pending_q[0].is_cfg && !(in_valid && in_ready)) begin
				if (answers_q.size() == 0 && !in_valid) begin
					if (drain_wait < 400) drain_wait++;
					else begin
						wr_cfg = 1'b1;
						cfg_wdata <= pending_q[0].hi;
						used_len = pending_q[0].hi;
						void'(pending_q.pop_front());
						n_cfg++;
						drain_wait = 0;
					end
				end
				in_valid <= 1'b0;
			end else if (!pending_q[0].is_cfg && (calm || $urandom_range(0, 99) >= 31)) begin
				in_valid <= 1'b1;
				operation <= pending_q[0].op;
				range_low <= pending_q[0].lo;
				range_high <= pending_q[0].hi;
				value <= pending_q[0].val;
			end else
				in_valid <= 1'b0;
		end else if (in_valid && in_ready)
			in_valid <= 1'b0;
		cfg_we <= wr_cfg;
		out_ready <= calm || $urandom_range(0, 99) >= 31;
	end

	// monitor
	always @(posedge clk) begin
		res_t e;
		if (out_valid && out_ready) begin
			n_results++;
			if (answers_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result ans=%0d", answer);
			end else begin
				e = answers_q.pop_front();
				if (e.ans !== answer || e.err !== range_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: exp ans=%0d err=%0b got ans=%0d err=%0b",
							n_results, $signed(e.ans), e.err, answer, range_error);
				end
			end
		end
	end

	initial begin
		int lo, hi, len;
		foreach (t_sum[i]) begin
			t_sum[i]  = '0;
			t_min[i]  = '0;
			t_max[i]  = '0;
			t_padd[i] = '0;
			t_pasg[i] = '0;
			t_af[i]   = 1'b0;
		end
		// directed
		push_item(lrst_pkg::OP_SUM, 0, 1024, 0);
		push_item(lrst_pkg::OP_MIN, 0, 1024, 0);
		push_item(lrst_pkg::OP_ASSIGN, 0, 1024, lrst_pkg::INT_MAX);
		push_item(lrst_pkg::OP_SUM, 0, 1024, 0);
		push_item(lrst_pkg::OP_ADD, 3, 700, 1);
		push_item(lrst_pkg::OP_MIN, 0, 1024, 0);
		push_item(lrst_pkg::OP_MAX, 0, 1024, 0);
		push_item(lrst_pkg::OP_ASSIGN, 1023, 1024, lrst_pkg::INT_MIN);
		push_item(lrst_pkg::OP_ADD, 1023, 1024, 32'hFFFF_FFFF);
		push_item(lrst_pkg::OP_MAX, 1000, 1024, 0);
		push_item(lrst_pkg::OP_SUM, 1023, 1024, 0);
		push_item(lrst_pkg::OP_SUM, 5, 5, 0);
		push_item(lrst_pkg::OP_ADD, 900, 10, 7);
		push_item(lrst_pkg::OP_SUM, 0, 1025, 0);
		push_item(lrst_pkg::OP_SUM, 0, 2047, 0);
		push_item(5, 0, 10, 9);
		push_item(7, 10, 5, 9);
		push_item(lrst_pkg::OP_ASSIGN, 0, 1024, 0);
		push_len(0);
		push_item(lrst_pkg::OP_SUM, 0, 1, 0);
		push_len(1);
		push_item(lrst_pkg::OP_ASSIGN, 0, 1, -5);
		push_item(lrst_pkg::OP_MIN, 0, 1, 0);
		push_item(lrst_pkg::OP_SUM, 0, 2, 0);
		push_len(2047);
		push_item(lrst_pkg::OP_MAX, 0, 1024, 0);
		// random, in phases of used length
		for (int ph = 0; ph < 6; ph++) begin
			len = (ph == 5) ? 1024 : $urandom_range(1, 1024);
			if (ph == 2) len = 16;
			push_len(len);
			for (int k = 0; k < 140; k++) begin
				lo = $urandom_range(0, len - 1);
				hi = $urandom_range(lo + 1, (lo + 64 < len) ? lo + 64 : len);
				if ($urandom_range(0, 9) == 0) hi = $urandom_range(lo + 1, len);
				if ($urandom_range(0, 15) == 0) begin
					lo = $urandom_range(0, 1023);
					hi = $urandom_range(0, 2047);
				end
				push_item(($urandom_range(0, 30) == 0) ? $urandom_range(5, 7)
					: $urandom_range(0, 4), lo, hi, pick_val());
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3000) @(posedge clk);
		calm = 1;
		repeat (3000) @(posedge clk);
		calm = 0;
		wait (pending_q.size() == 0 && !in_valid && answers_q.size() == 0);
		repeat (300) @(posedge clk);
		$display("ran %0d items and %0d length writes, %0d results checked",
			n_items, n_cfg, n_results);
		if (mismatches == 0 && answers_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

endmodule
